FILE: src/tre_pkg.sv
`default_nettype none

package tre_pkg;

   // Build options
   localparam bit DEVICE_RESET_TIER_DEF = 1'b0;
   localparam bit SCAN_REJOIN_DEF       = 1'b1;

   // Register file geometry
   localparam int NUM_REGS   = 8;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes
   localparam logic [2:0] REG_TIER1_LIMIT = 3'd0;
   localparam logic [2:0] REG_TIER2_LIMIT = 3'd1;
   localparam logic [2:0] REG_TIER3_LIMIT = 3'd2;
   localparam logic [2:0] REG_TIER4_LIMIT = 3'd3;
   localparam logic [2:0] REG_TIER1_GAP   = 3'd4;
   localparam logic [2:0] REG_TIER2_GAP   = 3'd5;
   localparam logic [2:0] REG_TIER3_GAP   = 3'd6;
   localparam logic [2:0] REG_TIER4_GAP   = 3'd7;

   // Register reset values
   localparam logic [31:0] TIER1_LIMIT_RST = 32'd30000;
   localparam logic [31:0] TIER2_LIMIT_RST = 32'd120000;
   localparam logic [31:0] TIER3_LIMIT_RST = 32'd600000;
   localparam logic [31:0] TIER4_LIMIT_RST = 32'd1800000;
   localparam logic [31:0] TIER1_GAP_RST   = 32'd5000;
   localparam logic [31:0] TIER2_GAP_RST   = 32'd15000;
   localparam logic [31:0] TIER3_GAP_RST   = 32'd60000;
   localparam logic [31:0] TIER4_GAP_RST   = 32'd300000;

   // Escalation tiers
   localparam logic [2:0] TIER_NONE = 3'd0;
   localparam logic [2:0] TIER_1    = 3'd1;
   localparam logic [2:0] TIER_2    = 3'd2;
   localparam logic [2:0] TIER_3    = 3'd3;
   localparam logic [2:0] TIER_4    = 3'd4;
   localparam logic [2:0] TIER_5    = 3'd5;

   typedef enum logic [2:0] {
      ACT_NONE         = 3'd0,
      ACT_RECONNECT    = 3'd1,
      ACT_REJOIN       = 3'd2,
      ACT_SCAN_REJOIN  = 3'd3,
      ACT_RADIO_RESET  = 3'd4,
      ACT_DEVICE_RESET = 3'd5
   } action_type;

   // Thresholds and gaps handed from the register file to the core
   typedef struct packed {
      logic [31:0] tier1_limit_ms;
      logic [31:0] tier2_limit_ms;
      logic [31:0] tier3_limit_ms;
      logic [31:0] tier4_limit_ms;
      logic [31:0] tier1_gap_ms;
      logic [31:0] tier2_gap_ms;
      logic [31:0] tier3_gap_ms;
      logic [31:0] tier4_gap_ms;
   } cfg_type;

   // One result item
   typedef struct packed {
      action_type  action;
      logic [2:0]  tier;
      logic        backing_off;
      logic [31:0] down_ms;
      logic [15:0] attempts;
      logic        recovered;
      logic [31:0] outage_ms;
   } rsp_type;

endpackage

`default_nettype wire

FILE: src/tre_if.sv
`default_nettype none

interface tre_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic        link_up;

   modport source (output valid, output now_ms, output link_up, input ready);
   modport sink   (input valid, input now_ms, input link_up, output ready);
endinterface

interface tre_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [2:0]  tier;
   logic        backing_off;
   logic [31:0] down_ms;
   logic [15:0] attempts;
   logic        recovered;
   logic [31:0] outage_ms;

   modport source (output valid, output action, output tier, output backing_off,
                   output down_ms, output attempts, output recovered,
                   output outage_ms, input ready);
   modport sink   (input valid, input action, input tier, input backing_off,
                   input down_ms, input attempts, input recovered,
                   input outage_ms, output ready);
endinterface

`default_nettype wire

FILE: src/tre_csr.sv
`default_nettype none

module tre_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [tre_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [tre_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [tre_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready,
   output tre_pkg::cfg_type                    cfg
);

   tre_pkg::cfg_type cfg_ff;
   logic [2:0]       idx;
   logic             wr_en;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   // Write registers on the access phase of a transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tier1_limit_ms <= tre_pkg::TIER1_LIMIT_RST;
         cfg_ff.tier2_limit_ms <= tre_pkg::TIER2_LIMIT_RST;
         cfg_ff.tier3_limit_ms <= tre_pkg::TIER3_LIMIT_RST;
         cfg_ff.tier4_limit_ms <= tre_pkg::TIER4_LIMIT_RST;
         cfg_ff.tier1_gap_ms   <= tre_pkg::TIER1_GAP_RST;
         cfg_ff.tier2_gap_ms   <= tre_pkg::TIER2_GAP_RST;
         cfg_ff.tier3_gap_ms   <= tre_pkg::TIER3_GAP_RST;
         cfg_ff.tier4_gap_ms   <= tre_pkg::TIER4_GAP_RST;
      end else if (wr_en) begin
         case (idx)
            tre_pkg::REG_TIER1_LIMIT: cfg_ff.tier1_limit_ms <= csr_pwdata;
            tre_pkg::REG_TIER2_LIMIT: cfg_ff.tier2_limit_ms <= csr_pwdata;
            tre_pkg::REG_TIER3_LIMIT: cfg_ff.tier3_limit_ms <= csr_pwdata;
            tre_pkg::REG_TIER4_LIMIT: cfg_ff.tier4_limit_ms <= csr_pwdata;
            tre_pkg::REG_TIER1_GAP:   cfg_ff.tier1_gap_ms   <= csr_pwdata;
            tre_pkg::REG_TIER2_GAP:   cfg_ff.tier2_gap_ms   <= csr_pwdata;
            tre_pkg::REG_TIER3_GAP:   cfg_ff.tier3_gap_ms   <= csr_pwdata;
            tre_pkg::REG_TIER4_GAP:   cfg_ff.tier4_gap_ms   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      case (idx)
         tre_pkg::REG_TIER1_LIMIT: csr_prdata = cfg_ff.tier1_limit_ms;
         tre_pkg::REG_TIER2_LIMIT: csr_prdata = cfg_ff.tier2_limit_ms;
         tre_pkg::REG_TIER3_LIMIT: csr_prdata = cfg_ff.tier3_limit_ms;
         tre_pkg::REG_TIER4_LIMIT: csr_prdata = cfg_ff.tier4_limit_ms;
         tre_pkg::REG_TIER1_GAP:   csr_prdata = cfg_ff.tier1_gap_ms;
         tre_pkg::REG_TIER2_GAP:   csr_prdata = cfg_ff.tier2_gap_ms;
         tre_pkg::REG_TIER3_GAP:   csr_prdata = cfg_ff.tier3_gap_ms;
         tre_pkg::REG_TIER4_GAP:   csr_prdata = cfg_ff.tier4_gap_ms;
         default:                  csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: src/tre_core.sv
`default_nettype none

module tre_core #(
   parameter bit DEVICE_RESET_TIER = tre_pkg::DEVICE_RESET_TIER_DEF,
   parameter bit SCAN_REJOIN       = tre_pkg::SCAN_REJOIN_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tre_pkg::cfg_type cfg,
   tre_req_if.sink               req,
   tre_rsp_if.source             rsp
);

   // Input stage
   logic        s1_valid_ff;
   logic [31:0] now_ff;
   logic        up_ff;

   // Result stage
   logic             rsp_valid_ff;
   tre_pkg::rsp_type rsp_ff;
   tre_pkg::rsp_type rsp_in;

   // Outage state
   logic        was_conn_ff, was_conn_in;
   logic        active_ff, active_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] last_ff, last_in;
   logic [15:0] count_ff, count_in;

   logic out_en;
   logic s1_adv;

   // Working values for the down path
   logic        fresh;
   logic [31:0] start_eff;
   logic [31:0] last_eff;
   logic [15:0] count_eff;
   logic [31:0] down;
   logic [31:0] since_last;
   logic [2:0]  tier;
   logic [31:0] gap;
   logic        backoff;
   logic [15:0] count_inc;
   tre_pkg::action_type act;

   assign out_en    = ~rsp_valid_ff | rsp.ready;
   assign s1_adv    = s1_valid_ff & out_en;
   assign req.ready = ~s1_valid_ff | out_en;

   // Start a fresh outage on the first down tick
   assign fresh      = was_conn_ff | ~active_ff;
   assign start_eff  = fresh ? now_ff : start_ff;
   assign last_eff   = fresh ? '0 : last_ff;
   assign count_eff  = fresh ? '0 : count_ff;
   assign down       = now_ff - start_eff;
   assign since_last = now_ff - last_eff;
   assign count_inc  = (count_eff == '1) ? count_eff : count_eff + 16'd1;

   // Pick the tier from the outage length
   always_comb begin
      if (down < cfg.tier1_limit_ms) begin
         tier = tre_pkg::TIER_1;
         gap  = cfg.tier1_gap_ms;
      end else if (down < cfg.tier2_limit_ms) begin
         tier = tre_pkg::TIER_2;
         gap  = cfg.tier2_gap_ms;
      end else if (down < cfg.tier3_limit_ms) begin
         tier = tre_pkg::TIER_3;
         gap  = cfg.tier3_gap_ms;
      end else if (!DEVICE_RESET_TIER || down < cfg.tier4_limit_ms) begin
         tier = tre_pkg::TIER_4;
         gap  = cfg.tier4_gap_ms;
      end else begin
         tier = tre_pkg::TIER_5;
         gap  = '0;
      end
   end

   assign backoff = (tier != tre_pkg::TIER_5) && (count_eff != '0) && (since_last < gap);

   // Map the tier to its action
   always_comb begin
      case (tier)
         tre_pkg::TIER_1: act = tre_pkg::ACT_RECONNECT;
         tre_pkg::TIER_2: act = tre_pkg::ACT_REJOIN;
         tre_pkg::TIER_3: act = SCAN_REJOIN ? tre_pkg::ACT_SCAN_REJOIN : tre_pkg::ACT_REJOIN;
         tre_pkg::TIER_4: act = tre_pkg::ACT_RADIO_RESET;
         default:         act = tre_pkg::ACT_DEVICE_RESET;
      endcase
   end

   // Build the result and the next outage state
   always_comb begin
      rsp_in      = '0;
      was_conn_in = was_conn_ff;
      active_in   = active_ff;
      start_in    = start_ff;
      last_in     = last_ff;
      count_in    = count_ff;
      if (up_ff) begin
         if (!was_conn_ff || active_ff) begin
            rsp_in.recovered = 1'b1;
            rsp_in.outage_ms = active_ff ? (now_ff - start_ff) : '0;
            rsp_in.attempts  = count_ff;
         end
         was_conn_in = 1'b1;
         active_in   = 1'b0;
         start_in    = '0;
         last_in     = '0;
         count_in    = '0;
      end else begin
         was_conn_in     = 1'b0;
         active_in       = 1'b1;
         start_in        = start_eff;
         rsp_in.tier     = tier;
         rsp_in.down_ms  = down;
         if (backoff) begin
            rsp_in.backing_off = 1'b1;
            last_in            = last_eff;
            count_in           = count_eff;
         end else begin
            rsp_in.action = act;
            last_in       = now_ff;
            count_in      = count_inc;
         end
         rsp_in.attempts = count_in;
      end
   end

   // Control and outage state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         was_conn_ff  <= 1'b0;
         active_ff    <= 1'b0;
         start_ff     <= '0;
         last_ff      <= '0;
         count_ff     <= '0;
      end else begin
         if (req.ready) begin
            s1_valid_ff <= req.valid;
         end
         if (out_en) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_adv) begin
            was_conn_ff <= was_conn_in;
            active_ff   <= active_in;
            start_ff    <= start_in;
            last_ff     <= last_in;
            count_ff    <= count_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         now_ff <= req.now_ms;
         up_ff  <= req.link_up;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.action      = rsp_ff.action;
   assign rsp.tier        = rsp_ff.tier;
   assign rsp.backing_off = rsp_ff.backing_off;
   assign rsp.down_ms     = rsp_ff.down_ms;
   assign rsp.attempts    = rsp_ff.attempts;
   assign rsp.recovered   = rsp_ff.recovered;
   assign rsp.outage_ms   = rsp_ff.outage_ms;

endmodule

`default_nettype wire

FILE: src/tiered_reconnect_escalation_top.sv
// Tiered reconnect escalation supervisor.
// req carries one supervision tick (now_ms, link_up); rsp returns one result
// per tick: action, tier, backing_off, down_ms, attempts, recovered, outage_ms.
// Both channels use valid/ready; a transfer happens when both are high.
// Each tick passes an input register and then a result register, which
// holds its result. One tick is taken every cycle while rsp is not
// stalled; the limit is the single compare-and-select pass between the two
// registers, which also updates the outage state.
// When rsp is stalled the result register holds and the input register
// still takes one more tick; req.ready then drops until rsp drains.
// Reset clears the outage state and loads the threshold and gap registers
// with their defaults; no ticks are in flight after reset.
// The csr_ APB port sets tier limits and gaps at byte address 4*index.
// Write it only while no tick is in flight. Reads return the register.
`default_nettype none

module tiered_reconnect_escalation_top #(
   parameter bit DEVICE_RESET_TIER = tre_pkg::DEVICE_RESET_TIER_DEF,
   parameter bit SCAN_REJOIN       = tre_pkg::SCAN_REJOIN_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   tre_req_if.sink                             req,
   tre_rsp_if.source                           rsp,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [tre_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [tre_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [tre_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);

   tre_pkg::cfg_type cfg;

   // Threshold and gap registers
   tre_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Per-tick escalation logic
   tre_core #(
      .DEVICE_RESET_TIER (DEVICE_RESET_TIER),
      .SCAN_REJOIN       (SCAN_REJOIN)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire
